// ===== sv/witt_pkg.sv =====
// ----------------------------------------------------------------------------
// witt_pkg: shared types and constants of the Winograd input tile transform
// Plane geometry, sample and value widths, the tile record that moves from
// the window line to the transform engine, and the stream bus widths.
// ----------------------------------------------------------------------------
package witt_pkg;

   localparam int PLANE_WIDTH  = 8;
   localparam int PLANE_HEIGHT = 8;
   localparam int SAMPLE_BITS  = 16;
   localparam int VALUE_BITS   = SAMPLE_BITS + 2;
   localparam int PARTIAL_BITS = SAMPLE_BITS + 1;

   localparam int COL_BITS = $clog2(PLANE_WIDTH);
   localparam int ROW_BITS = $clog2(PLANE_HEIGHT);
   localparam int TILES_X  = (PLANE_WIDTH + 1) / 2;
   localparam int TILES_Y  = (PLANE_HEIGHT + 1) / 2;

   // Three full rows plus four samples cover a 4x4 window; tap 0 is the
   // incoming sample, so the chain holds one fewer.
   localparam int TAP_COUNT  = 3 * PLANE_WIDTH + 4;
   localparam int CELL_COUNT = TAP_COUNT - 1;

   localparam int TILE_BITS  = 4;
   localparam int ELEM_BITS  = 4;
   localparam int TILE_ELEMS = 16;
   localparam logic [ELEM_BITS-1:0] LAST_ELEM = ELEM_BITS'(TILE_ELEMS - 1);

   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = TILE_BITS + ELEM_BITS + VALUE_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic signed [SAMPLE_BITS-1:0]  sample_type;
   typedef logic signed [PARTIAL_BITS-1:0] partial_type;
   typedef logic signed [VALUE_BITS-1:0]   value_type;

   typedef sample_type  [3:0][3:0] window_type;
   typedef partial_type [3:0][3:0] rows_type;

   typedef struct packed {
      logic                 done;
      logic [TILE_BITS-1:0] tile_index;
      window_type           x;
   } tile_type;

endpackage

// ===== sv/witt_cell.sv =====
// ----------------------------------------------------------------------------
// witt_cell: one sample cell of the window line
// Holds one sample and takes its neighbor's sample on every accepted beat.
// ----------------------------------------------------------------------------
module witt_cell (
   input  logic                 clock,
   input  logic                 shift_en,
   input  witt_pkg::sample_type d,
   output witt_pkg::sample_type q
);

   witt_pkg::sample_type q_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         q_ff <= d;
      end
   end

   assign q = q_ff;

endmodule

// ===== sv/witt_window_line.sv =====
// ----------------------------------------------------------------------------
// witt_window_line: sample chain, raster position and tile detection
// A chain of cells keeps the last rows of the plane. When the incoming beat
// is the last in-plane sample of a tile, the 4x4 window is cut out of the
// chain taps with zero padding at the plane edges.
// ----------------------------------------------------------------------------
module witt_window_line (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  witt_pkg::sample_type sample,
   output witt_pkg::tile_type   tile
);

   logic [witt_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [witt_pkg::ROW_BITS-1:0] row_ff, row_in;
   witt_pkg::sample_type          taps [witt_pkg::TAP_COUNT];
   witt_pkg::sample_type          win  [4][4];
   logic                          last_row, last_col, first_row, first_col;
   logic                          row_end, col_end;
   logic [witt_pkg::ROW_BITS-1:0] ty;
   logic [witt_pkg::COL_BITS-1:0] tx;

   assign taps[0] = sample;

   for (genvar n = 0; n < witt_pkg::CELL_COUNT; n++) begin : g_cell
      witt_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .d        (taps[n]),
         .q        (taps[n+1])
      );
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == witt_pkg::COL_BITS'(witt_pkg::PLANE_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == witt_pkg::ROW_BITS'(witt_pkg::PLANE_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + witt_pkg::ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + witt_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // A tile ends on an even position from 2 on, and the last tile of an axis
   // ends on the final position, where its window is one step short.
   assign last_row  = (row_ff == witt_pkg::ROW_BITS'(witt_pkg::PLANE_HEIGHT - 1));
   assign last_col  = (col_ff == witt_pkg::COL_BITS'(witt_pkg::PLANE_WIDTH - 1));
   assign first_row = (row_ff == witt_pkg::ROW_BITS'(2));
   assign first_col = (col_ff == witt_pkg::COL_BITS'(2));
   assign row_end   = last_row || (!row_ff[0] && row_ff >= witt_pkg::ROW_BITS'(2));
   assign col_end   = last_col || (!col_ff[0] && col_ff >= witt_pkg::COL_BITS'(2));

   assign ty = last_row ? witt_pkg::ROW_BITS'(witt_pkg::TILES_Y - 1)
                        : (row_ff >> 1) - witt_pkg::ROW_BITS'(1);
   assign tx = last_col ? witt_pkg::COL_BITS'(witt_pkg::TILES_X - 1)
                        : (col_ff >> 1) - witt_pkg::COL_BITS'(1);

   for (genvar i = 0; i < 4; i++) begin : g_row
      for (genvar j = 0; j < 4; j++) begin : g_col
         localparam int RF = 3 - i;
         localparam int RL = (i == 3) ? 0 : 2 - i;
         localparam int CF = 3 - j;
         localparam int CL = (j == 3) ? 0 : 2 - j;
         localparam int W  = witt_pkg::PLANE_WIDTH;
         logic pad;

         assign pad = (last_row && (i == 3)) || (first_row && (i == 0)) ||
                      (last_col && (j == 3)) || (first_col && (j == 0));
         assign win[i][j] = pad ? '0 :
                            last_row ? (last_col ? taps[RL*W+CL] : taps[RL*W+CF])
                                     : (last_col ? taps[RF*W+CL] : taps[RF*W+CF]);
      end
   end

   always_comb begin
      tile.done       = row_end && col_end;
      tile.tile_index = witt_pkg::TILE_BITS'(ty * witt_pkg::TILES_X + tx);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            tile.x[i][j] = win[i][j];
         end
      end
   end

endmodule

// ===== sv/witt_transform_engine.sv =====
// ----------------------------------------------------------------------------
// witt_transform_engine: transpose(B) x B over one tile, one element a beat
// On load the column pass is registered; each output beat then applies the
// row pass to one element and places it in the output register.
// ----------------------------------------------------------------------------
module witt_transform_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load_valid,
   input  witt_pkg::tile_type                  load_tile,
   output logic                                load_take,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [witt_pkg::TILE_BITS-1:0]      rsp_tile,
   output logic [witt_pkg::ELEM_BITS-1:0]      rsp_elem,
   output witt_pkg::value_type                 rsp_value,
   output logic                                rsp_last
);

   logic                              active_ff, active_in;
   logic [witt_pkg::ELEM_BITS-1:0]    elem_ff, elem_in;
   logic [witt_pkg::TILE_BITS-1:0]    tile_ff;
   witt_pkg::rows_type                t_ff, t_in;
   logic                              out_free, emit;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [witt_pkg::TILE_BITS-1:0]    rsp_tile_ff;
   logic [witt_pkg::ELEM_BITS-1:0]    rsp_elem_ff;
   witt_pkg::value_type               rsp_value_ff, v;
   logic                              rsp_last_ff;
   witt_pkg::partial_type [3:0]       t_row;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = active_ff && out_free;
   assign load_take = load_valid && (!active_ff || (emit && elem_ff == witt_pkg::LAST_ELEM));

   // Column pass: rows of transpose(B) applied to the window.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         t_in[0][j] = witt_pkg::partial_type'($signed(load_tile.x[0][j]))
                    - witt_pkg::partial_type'($signed(load_tile.x[2][j]));
         t_in[1][j] = witt_pkg::partial_type'($signed(load_tile.x[1][j]))
                    + witt_pkg::partial_type'($signed(load_tile.x[2][j]));
         t_in[2][j] = witt_pkg::partial_type'($signed(load_tile.x[2][j]))
                    - witt_pkg::partial_type'($signed(load_tile.x[1][j]));
         t_in[3][j] = witt_pkg::partial_type'($signed(load_tile.x[1][j]))
                    - witt_pkg::partial_type'($signed(load_tile.x[3][j]));
      end
   end

   // Row pass for the element at hand.
   always_comb begin
      t_row = t_ff[elem_ff[3:2]];
      case (elem_ff[1:0])
         2'd0:    v = witt_pkg::value_type'(t_row[0]) - witt_pkg::value_type'(t_row[2]);
         2'd1:    v = witt_pkg::value_type'(t_row[1]) + witt_pkg::value_type'(t_row[2]);
         2'd2:    v = witt_pkg::value_type'(t_row[2]) - witt_pkg::value_type'(t_row[1]);
         2'd3:    v = witt_pkg::value_type'(t_row[1]) - witt_pkg::value_type'(t_row[3]);
         default: v = '0;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      elem_in   = elem_ff;
      if (emit) begin
         elem_in = elem_ff + witt_pkg::ELEM_BITS'(1);
         if (elem_ff == witt_pkg::LAST_ELEM) begin
            active_in = 1'b0;
         end
      end
      if (load_take) begin
         active_in = 1'b1;
         elem_in   = '0;
      end
      rsp_valid_in = out_free ? active_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         elem_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         elem_ff      <= elem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_take) begin
         t_ff    <= t_in;
         tile_ff <= load_tile.tile_index;
      end
      if (emit) begin
         rsp_tile_ff  <= tile_ff;
         rsp_elem_ff  <= elem_ff;
         rsp_value_ff <= v;
         rsp_last_ff  <= (elem_ff == witt_pkg::LAST_ELEM);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tile  = rsp_tile_ff;
   assign rsp_elem  = rsp_elem_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== sv/winograd_input_tile_transform_unit.sv =====
// ----------------------------------------------------------------------------
// winograd_input_tile_transform_unit: F(2x2,3x3) input tile transform
// Streams samples of an 8x8 plane in raster order and returns the 16
// transformed elements of every 4x4 tile (stride 2, zero padding of one).
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one signed sample per beat. Planes follow each
//   other with no gap; the raster position wraps after the last sample.
//   The rsp channel carries one element per beat, tiles in completion order,
//   elements row-major, with rsp_tlast on the sixteenth element of a tile.
//   A completed tile passes through the holding slot, the column-pass
//   register and the output register; its 16 elements then leave on
//   consecutive cycles while rsp_tready is high, a pace set by the
//   one-element-per-cycle row pass. Over a plane, 64 samples yield 256
//   elements; the engine idles while the first tile of the next plane
//   fills. One completed tile can wait in a holding slot while another is
//   being sent; req_tready drops while that slot is full, which in a tile
//   row stalls the input. When the receiver stalls, the current element
//   holds in the output register and the transform waits. Reset clears
//   the raster position and all valid flags; the sample chain needs no
//   clearing, since padding masks every tap that is not yet part of the
//   current plane.
// ----------------------------------------------------------------------------
module winograd_input_tile_transform_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] sample
   input  logic [witt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] tile_index, [7:4] element_index, [25:8] value, rest zero
   output logic [witt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);

   logic                              accept;
   witt_pkg::tile_type                tile_evt;
   witt_pkg::tile_type                pend_ff;
   logic                              pend_valid_ff, pend_valid_in;
   logic                              load_take;
   logic [witt_pkg::TILE_BITS-1:0]    rsp_tile;
   logic [witt_pkg::ELEM_BITS-1:0]    rsp_elem;
   witt_pkg::value_type               rsp_value;

   assign req_tready = !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;

   witt_window_line u_line (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (witt_pkg::sample_type'(req_tdata[witt_pkg::SAMPLE_BITS-1:0])),
      .tile   (tile_evt)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (load_take) begin
         pend_valid_in = 1'b0;
      end
      if (accept && tile_evt.done) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && tile_evt.done) begin
         pend_ff <= tile_evt;
      end
   end

   witt_transform_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .load_valid (pend_valid_ff),
      .load_tile  (pend_ff),
      .load_take  (load_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_tile   (rsp_tile),
      .rsp_elem   (rsp_elem),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = witt_pkg::RSP_DATA_BITS'({rsp_value, rsp_elem, rsp_tile});

   // The last flag sits exactly on the final element of a tile.
   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_elem == witt_pkg::LAST_ELEM)))
      else $error("tlast does not match the final element of a tile");

   // Within a tile the elements leave without gaps and in order.
   a_tile_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_elem == $past(rsp_elem) + witt_pkg::ELEM_BITS'(1)
          && rsp_tile == $past(rsp_tile)))
      else $error("tile elements not sent back to back in order");

   // A new tile starts at element zero.
   a_tile_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (!rsp_tvalid || rsp_elem == '0))
      else $error("tile does not start at element zero");

   // A completed tile is only captured while the holding slot is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !load_take) |=> (pend_valid_ff && $stable(pend_ff)))
      else $error("held tile lost before the engine took it");

endmodule
